/* rtl/core/sasl_pkg.sv */
package sasl_pkg;

  localparam int unsigned CmdW      = 16;
  localparam int unsigned DeadzoneW = 14;
  localparam int unsigned AngleMaxW = 15;
  localparam int unsigned RateW     = 16;
  localparam int unsigned ScaleW    = 16;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIdxW   = 2;

  // shared divider: 32 bit dividend, quotient known to stay below 2^17
  localparam int unsigned DivNumW   = 32;
  localparam int unsigned DivQuoW   = 17;
  localparam int unsigned DivDenW   = 17;
  localparam int unsigned DivCntW   = 5;

  localparam logic [CfgIdxW-1:0] REG_DEADZONE_WIDTH = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_ANGLE      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_MAX_RATE       = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPEED_SCALE    = 2'd3;

  localparam logic [DeadzoneW-1:0] DEADZONE_WIDTH_RST = 14'd1638;
  localparam logic [AngleMaxW-1:0] MAX_ANGLE_RST      = 15'd9830;
  localparam logic [RateW-1:0]     MAX_RATE_RST       = 16'd8192;
  localparam logic [ScaleW-1:0]    SPEED_SCALE_RST    = 16'd7680;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] dividend;
    logic [DivDenW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DivQuoW-1:0] quotient;
  } div_rsp_t;

endpackage

/* rtl/core/sasl_div.sv */
module sasl_div (
  input  logic             clk,
  input  logic             rst,
  input  sasl_pkg::div_req_t req,
  output sasl_pkg::div_rsp_t rsp
);
  import sasl_pkg::*;

  logic                busy;
  logic [DivCntW-1:0]  cnt;
  logic [DivDenW-1:0]  rem;
  logic [DivQuoW-1:0]  quo;
  logic [DivDenW-1:0]  divisor;
  logic                done;

  logic [DivDenW:0]    trial;
  logic                fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem, quo[DivQuoW-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= DivCntW'(DivQuoW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DivCntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      // upper dividend bits start as the partial remainder
      rem     <= DivDenW'(req.dividend[DivNumW-1:DivQuoW]);
      quo     <= req.dividend[DivQuoW-1:0];
      divisor <= req.divisor;
    end else if (busy) begin
      rem <= fits ? DivDenW'(trial - {1'b0, divisor}) : trial[DivDenW-1:0];
      quo <= {quo[DivQuoW-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* rtl/core/steer_angle_slew_limiter_core.sv */
// channel  | signals                                      | direction
// command  | cmd_valid, cmd_stall, steer_command,         | in
//          | forward_speed, time_step                     |
// result   | res_valid, res_stall, new_angle, rate_limited| out
// config   | cfg_we, cfg_index, cfg_data                  | in
//
// one word goes from accept to result through two divider passes (start, 17
// quotient bits, done), three multiplier steps and one finishing step, and
// the next word is taken only once the core is idle again. with zero speed
// scale at standstill the second pass is skipped.
// rst is synchronous: registers return to defaults, angle clears to zero.
// a finished result waits in the output register; a new command is taken
// while it waits, and the next result waits in the last step until it leaves.
module steer_angle_slew_limiter_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cmd_valid,
  output logic                                   cmd_stall,
  input  logic signed [15:0]                     steer_command,
  input  logic signed [15:0]                     forward_speed,
  input  logic [15:0]                            time_step,
  output logic                                   res_valid,
  input  logic                                   res_stall,
  output logic signed [15:0]                     new_angle,
  output logic                                   rate_limited,
  input  logic                                   cfg_we,
  input  logic [sasl_pkg::CfgIdxW-1:0]           cfg_index,
  input  logic [sasl_pkg::CfgDataW-1:0]          cfg_data
);
  import sasl_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DIV_DZ  = 4'd1;
  localparam logic [3:0] S_WAIT_DZ = 4'd2;
  localparam logic [3:0] S_DIV_SF  = 4'd3;
  localparam logic [3:0] S_WAIT_SF = 4'd4;
  localparam logic [3:0] S_MUL_A   = 4'd5;
  localparam logic [3:0] S_MUL_B   = 4'd6;
  localparam logic [3:0] S_MUL_C   = 4'd7;
  localparam logic [3:0] S_FINISH  = 4'd8;

  logic [3:0]            state, state_next;

  logic [DeadzoneW-1:0]  deadzone_width;
  logic [AngleMaxW-1:0]  max_angle;
  logic [RateW-1:0]      max_rate;
  logic [ScaleW-1:0]     speed_scale;

  logic signed [15:0]    steer_angle;

  logic                  cmd_neg;
  logic [15:0]           cmd_mag;
  logic [15:0]           speed_mag;
  logic [15:0]           dt;
  logic [15:0]           inp;
  logic [DivQuoW-1:0]    sf;
  logic [47:0]           prod;
  logic signed [15:0]    tgt;

  div_req_t              div_req;
  div_rsp_t              div_rsp;

  logic                  cmd_take;
  logic                  res_free;
  logic [16:0]           sf_den;
  logic [15:0]           dz_diff;
  logic                  dz_out;

  logic [30:0]           mul_a;
  logic [16:0]           mul_b;
  logic [47:0]           mul_p;

  logic [17:0]           lim;
  logic signed [17:0]    delta;
  logic [16:0]           delta_mag;
  logic                  limited;
  logic signed [18:0]    nv_wide;
  logic signed [15:0]    nv;

  sasl_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && !cmd_stall;
  assign res_free  = !res_valid || !res_stall;

  assign dz_out  = cmd_mag >= {2'b00, deadzone_width};
  assign dz_diff = cmd_mag - {2'b00, deadzone_width};
  assign sf_den  = {1'b0, speed_scale} + {1'b0, speed_mag};

  always_comb begin
    div_req = '0;
    case (state)
      S_DIV_DZ: begin
        div_req.start    = 1'b1;
        div_req.dividend = dz_out ? {1'b0, dz_diff, 15'd0} : '0;
        div_req.divisor  = 17'd32768 - {3'b000, deadzone_width};
      end
      S_DIV_SF: begin
        div_req.start    = (sf_den != '0);
        div_req.dividend = {speed_scale, 16'd0};
        div_req.divisor  = sf_den;
      end
      default: ;
    endcase
  end

  // one shared multiplier, operands chosen by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL_A: begin
        mul_a = {15'd0, inp};
        mul_b = {2'b00, max_angle};
      end
      S_MUL_B: begin
        mul_a = prod[30:0];
        mul_b = sf;
      end
      S_MUL_C: begin
        mul_a = {15'd0, max_rate};
        mul_b = {1'b0, dt};
      end
      default: ;
    endcase
  end
  assign mul_p = {17'd0, mul_a} * {31'd0, mul_b};

  // final clamp toward the target
  always_comb begin
    lim       = prod[31:14];
    delta     = 18'(tgt) - 18'(steer_angle);
    delta_mag = delta[17] ? 17'(-delta) : delta[16:0];
    limited   = {1'b0, delta_mag} > lim;
    if (delta[17])
      nv_wide = 19'(steer_angle) - signed'({1'b0, lim});
    else
      nv_wide = 19'(steer_angle) + signed'({1'b0, lim});
    nv = limited ? nv_wide[15:0] : tgt;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (cmd_take) state_next = S_DIV_DZ;
      S_DIV_DZ:  state_next = S_WAIT_DZ;
      S_WAIT_DZ: if (div_rsp.done) state_next = S_DIV_SF;
      S_DIV_SF:  state_next = (sf_den == '0) ? S_MUL_A : S_WAIT_SF;
      S_WAIT_SF: if (div_rsp.done) state_next = S_MUL_A;
      S_MUL_A:   state_next = S_MUL_B;
      S_MUL_B:   state_next = S_MUL_C;
      S_MUL_C:   state_next = S_FINISH;
      S_FINISH:  if (res_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      res_valid      <= 1'b0;
      steer_angle    <= '0;
      deadzone_width <= DEADZONE_WIDTH_RST;
      max_angle      <= MAX_ANGLE_RST;
      max_rate       <= MAX_RATE_RST;
      speed_scale    <= SPEED_SCALE_RST;
    end else begin
      state <= state_next;
      if (res_valid && !res_stall)
        res_valid <= 1'b0;
      if (state == S_FINISH && res_free) begin
        res_valid   <= 1'b1;
        steer_angle <= nv;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_DEADZONE_WIDTH: deadzone_width <= cfg_data[DeadzoneW-1:0];
          REG_MAX_ANGLE:      max_angle      <= cfg_data[AngleMaxW-1:0];
          REG_MAX_RATE:       max_rate       <= cfg_data[RateW-1:0];
          REG_SPEED_SCALE:    speed_scale    <= cfg_data[ScaleW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_neg   <= steer_command[15];
      cmd_mag   <= steer_command[15] ? 16'(-steer_command) : steer_command;
      speed_mag <= forward_speed[15] ? 16'(-forward_speed) : forward_speed;
      dt        <= time_step;
    end
    if (state == S_WAIT_DZ && div_rsp.done)
      inp <= div_rsp.quotient[15:0];
    if (state == S_DIV_SF && sf_den == '0)
      sf <= 17'h10000;
    if (state == S_WAIT_SF && div_rsp.done)
      sf <= div_rsp.quotient;
    if (state == S_MUL_A || state == S_MUL_B || state == S_MUL_C)
      prod <= mul_p;
    if (state == S_MUL_C)
      tgt <= cmd_neg ? 16'(-prod[46:31]) : prod[46:31];
    if (state == S_FINISH && res_free) begin
      new_angle    <= nv;
      rate_limited <= limited;
    end
  end

endmodule
